// ===== rtl/assert_macros.svh =====
// Concurrent check helpers. Both sample on the rising edge of clk and stay
// quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hsvpg_pkg.sv =====
package hsvpg_pkg;

	localparam int PosW  = 13;
	localparam int SegW  = 10;
	localparam int DimW  = 11;
	localparam int ChanW = 8;
	localparam int RecW  = 18;
	localparam int RsW   = 14;
	localparam int IdxW  = 2;

	localparam int InDataW  = 40;
	localparam int OutDataW = 48;

	localparam logic [IdxW-1:0] RegSeg    = 2'd0;
	localparam logic [IdxW-1:0] RegWidth  = 2'd1;
	localparam logic [IdxW-1:0] RegHeight = 2'd2;

	localparam int SegResetVal = 66;
	localparam int DimResetVal = 400;
	localparam logic [SegW-1:0] SegReset = SegW'(SegResetVal);
	localparam logic [DimW-1:0] DimReset = DimW'(DimResetVal);

	// Numerators of the reciprocals held for the datapath.
	localparam int HueNum   = 8192;
	localparam int UpNum    = 255000;
	localparam int ScaleNum = 256000;

	localparam logic [RsW-1:0]  RsReset = RsW'(HueNum / SegResetVal);
	localparam logic [RecW-1:0] HqReset = RecW'(UpNum / SegResetVal);
	localparam logic [RecW-1:0] RdReset = RecW'(ScaleNum / DimResetVal);

	localparam int DivSteps = RecW;

	localparam int HueStages   = 6;
	localparam int ShadeStages = 10;
	localparam int Latency     = HueStages + ShadeStages;

	// Hue bar sextants.
	localparam logic [2:0] SextRy = 3'd0;
	localparam logic [2:0] SextYg = 3'd1;
	localparam logic [2:0] SextGc = 3'd2;
	localparam logic [2:0] SextCb = 3'd3;
	localparam logic [2:0] SextBm = 3'd4;
	localparam logic [2:0] SextMr = 3'd5;

	// floor(t / 6) = (t * Recip6) >> 16, exact for t below 32768.
	localparam logic [15:0] Recip6 = 16'd10923;
	localparam int Recip6Shift = 16;

	// floor(v / 1000) = (v * Recip1000) >> 39, exact for v below 2^29.
	localparam int Div1000InW   = 29;
	localparam int Div1000OutW  = 20;
	localparam int Recip1000W   = 30;
	localparam int Div1000Shift = 39;
	localparam logic [Recip1000W-1:0] Recip1000 = 30'd549755814;
	localparam int Div1000PW = Div1000InW + Recip1000W;

	localparam logic [9:0] Thousand = 10'd1000;

	typedef struct packed {
		logic [SegW-1:0] seg;
		logic [DimW-1:0] width;
		logic [DimW-1:0] height;
		logic [RsW-1:0]  rs;
		logic [RecW-1:0] hq;
		logic [RecW-1:0] rw;
		logic [RecW-1:0] rh;
	} hsvpg_cfg_t;

	function automatic logic [Div1000OutW-1:0] div1000(input logic [Div1000InW-1:0] v);
		logic [Div1000PW-1:0] p;
		p = Div1000PW'(v) * Div1000PW'(Recip1000);
		return p[Div1000PW-1:Div1000Shift];
	endfunction

endpackage

// ===== rtl/hsvpg_recip.sv =====
`include "assert_macros.svh"

module hsvpg_recip (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [hsvpg_pkg::IdxW-1:0]  cfg_index,
	input  logic [hsvpg_pkg::DimW-1:0]  cfg_wdata,
	output hsvpg_pkg::hsvpg_cfg_t       cfg,
	output logic                        busy
);
	import hsvpg_pkg::*;

	localparam logic [1:0] JobRs = 2'd0;
	localparam logic [1:0] JobHq = 2'd1;
	localparam logic [1:0] JobRw = 2'd2;
	localparam logic [1:0] JobRh = 2'd3;
	localparam int CntW = $clog2(DivSteps + 2);
	localparam logic [CntW-1:0] CntDone = CntW'(DivSteps + 1);

	logic [SegW-1:0] seg_q;
	logic [DimW-1:0] width_q;
	logic [DimW-1:0] height_q;
	logic [SegW-1:0] seg_eff;
	logic [DimW-1:0] width_eff;
	logic [DimW-1:0] height_eff;
	logic [RsW-1:0]  rs_q;
	logic [RecW-1:0] hq_q;
	logic [RecW-1:0] rw_q;
	logic [RecW-1:0] rh_q;
	logic            busy_q;
	logic [1:0]      job_q;
	logic [CntW-1:0] cnt_q;
	logic [RecW-1:0] num_q;
	logic [DimW-1:0] rem_q;
	logic [RecW-1:0] num_sel;
	logic [DimW-1:0] den_sel;
	logic [DimW:0]   trial;
	logic            fits;
	logic [23:0]     rs_span;
	logic [29:0]     rw_span;
	logic [29:0]     rh_span;
	logic            hue_recip_ok;
	logic            scale_recip_ok;

	assign seg_eff    = (seg_q == '0) ? SegW'(1) : seg_q;
	assign width_eff  = (width_q == '0) ? DimW'(1) : width_q;
	assign height_eff = (height_q == '0) ? DimW'(1) : height_q;

	always_comb begin
		case (job_q)
			JobRs: begin
				num_sel = RecW'(HueNum);
				den_sel = DimW'(seg_eff);
			end
			JobHq: begin
				num_sel = RecW'(UpNum);
				den_sel = DimW'(seg_eff);
			end
			JobRw: begin
				num_sel = RecW'(ScaleNum);
				den_sel = width_eff;
			end
			JobRh: begin
				num_sel = RecW'(ScaleNum);
				den_sel = height_eff;
			end
			default: begin
				num_sel = '0;
				den_sel = DimW'(1);
			end
		endcase
	end

	assign trial = {rem_q, num_q[RecW-1]};
	assign fits  = trial >= {1'b0, den_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q    <= SegReset;
			width_q  <= DimReset;
			height_q <= DimReset;
		end else if (cfg_wen) begin
			case (cfg_index)
				RegSeg:    seg_q    <= cfg_wdata[SegW-1:0];
				RegWidth:  width_q  <= cfg_wdata;
				RegHeight: height_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	// Any write reruns all four divisions, one after the other.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			job_q  <= JobRs;
			cnt_q  <= '0;
			rs_q   <= RsReset;
			hq_q   <= HqReset;
			rw_q   <= RdReset;
			rh_q   <= RdReset;
		end else if (cfg_wen) begin
			busy_q <= 1'b1;
			job_q  <= JobRs;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CntDone) begin
				case (job_q)
					JobRs:   rs_q <= num_q[RsW-1:0];
					JobHq:   hq_q <= num_q;
					JobRw:   rw_q <= num_q;
					JobRh:   rh_q <= num_q;
					default: ;
				endcase
				cnt_q <= '0;
				if (job_q == JobRh) begin
					busy_q <= 1'b0;
				end else begin
					job_q <= job_q + 2'd1;
				end
			end else begin
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	// Restoring divider, one quotient bit per cycle shifted in behind the numerator.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (cnt_q == '0) begin
				num_q <= num_sel;
				rem_q <= '0;
			end else if (cnt_q != CntDone) begin
				num_q <= {num_q[RecW-2:0], fits};
				rem_q <= fits ? DimW'(trial - {1'b0, den_sel}) : trial[DimW-1:0];
			end
		end
	end

	assign cfg = '{
		seg:    seg_eff,
		width:  width_eff,
		height: height_eff,
		rs:     rs_q,
		hq:     hq_q,
		rw:     rw_q,
		rh:     rh_q
	};
	assign busy = busy_q;

	assign rs_span = 24'(rs_q) * 24'(seg_eff);
	assign rw_span = 30'(rw_q) * 30'(width_eff);
	assign rh_span = 30'(rh_q) * 30'(height_eff);

	assign hue_recip_ok = (rs_span <= 24'(HueNum))
		&& (rs_span + 24'(seg_eff) > 24'(HueNum));
	assign scale_recip_ok = (rw_span <= 30'(ScaleNum))
		&& (rw_span + 30'(width_eff) > 30'(ScaleNum))
		&& (rh_span <= 30'(ScaleNum))
		&& (rh_span + 30'(height_eff) > 30'(ScaleNum));

	`CHK_NEXT(a_write_starts_recompute, cfg_wen, busy_q, "config write did not start recompute")
	`CHK_IMPL(a_hue_recip_exact, !busy_q, hue_recip_ok, "hue reciprocal does not match segment")
	`CHK_IMPL(a_scale_recips_exact, !busy_q, scale_recip_ok, "square reciprocals do not match size")

endmodule

// ===== rtl/hsvpg_hue.sv =====
module hsvpg_hue (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hsvpg_pkg::PosW-1:0]    pos,
	input  logic [hsvpg_pkg::DimW-1:0]    x,
	input  logic [hsvpg_pkg::DimW-1:0]    y,
	input  hsvpg_pkg::hsvpg_cfg_t         cfg,
	output logic [hsvpg_pkg::ChanW-1:0]   red,
	output logic [hsvpg_pkg::ChanW-1:0]   green,
	output logic [hsvpg_pkg::ChanW-1:0]   blue,
	output logic [hsvpg_pkg::DimW-1:0]    sq_x,
	output logic [hsvpg_pkg::DimW-1:0]    sq_y
);
	import hsvpg_pkg::*;

	localparam int TqPW = PosW + RsW;
	localparam int TsPW = PosW + SegW;
	localparam int Q6PW = PosW + 16;
	localparam int UmPW = RecW + SegW;

	logic [DimW-1:0]  xmax;
	logic [DimW-1:0]  ymax;
	logic [TqPW-1:0]  tq_prod;
	logic [TsPW-1:0]  ts_prod;
	logic [PosW-1:0]  rem_full;
	logic             rem_ge;
	logic [Q6PW-1:0]  q6_prod;
	logic [UmPW-1:0]  um_prod;
	logic [PosW-1:0]  sext_full;
	logic [Div1000OutW-1:0] up_full;
	logic [ChanW-1:0] down_s5;

	logic [PosW-1:0]  pos_s1;
	logic [PosW-1:0]  tq_s1;
	logic [PosW-1:0]  tq_s2;
	logic [DimW-1:0]  rem_s2;
	logic [PosW-1:0]  t_s3;
	logic [SegW-1:0]  m_s3;
	logic [PosW-1:0]  t_s4;
	logic [10:0]      q6_s4;
	logic [RecW-1:0]  um_s4;
	logic [2:0]       sext_s5;
	logic [ChanW-1:0] up_s5;
	logic [ChanW-1:0] red_s6;
	logic [ChanW-1:0] green_s6;
	logic [ChanW-1:0] blue_s6;
	logic [DimW-1:0]  x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [DimW-1:0]  y_s1, y_s2, y_s3, y_s4, y_s5, y_s6;

	assign xmax = cfg.width - DimW'(1);
	assign ymax = cfg.height - DimW'(1);

	// The estimate pos * floor(8192/seg) >> 13 is the quotient or one below it.
	assign tq_prod = TqPW'(pos) * TqPW'(cfg.rs);

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pos;
			tq_s1  <= tq_prod[2*PosW-1:PosW];
			x_s1   <= (x > xmax) ? xmax : x;
			y_s1   <= (y > ymax) ? ymax : y;
		end
	end

	assign ts_prod  = TsPW'(tq_s1) * TsPW'(cfg.seg);
	assign rem_full = pos_s1 - ts_prod[PosW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			tq_s2  <= tq_s1;
			rem_s2 <= rem_full[DimW-1:0];
			x_s2   <= x_s1;
			y_s2   <= y_s1;
		end
	end

	assign rem_ge = rem_s2 >= DimW'(cfg.seg);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3 <= tq_s2 + PosW'(rem_ge);
			m_s3 <= rem_ge ? SegW'(rem_s2 - DimW'(cfg.seg)) : rem_s2[SegW-1:0];
			x_s3 <= x_s2;
			y_s3 <= y_s2;
		end
	end

	assign q6_prod = Q6PW'(t_s3) * Q6PW'(Recip6);
	assign um_prod = UmPW'(cfg.hq) * UmPW'(m_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4  <= t_s3;
			q6_s4 <= q6_prod[Recip6Shift+10:Recip6Shift];
			um_s4 <= um_prod[RecW-1:0];
			x_s4  <= x_s3;
			y_s4  <= y_s3;
		end
	end

	// Segment index modulo six; the ramp stays below 255.
	assign sext_full = t_s4 - PosW'(q6_s4) * PosW'(6);
	assign up_full   = div1000(Div1000InW'(um_s4));

	always_ff @(posedge clk) begin
		if (en) begin
			sext_s5 <= sext_full[2:0];
			up_s5   <= up_full[ChanW-1:0];
			x_s5    <= x_s4;
			y_s5    <= y_s4;
		end
	end

	assign down_s5 = ChanW'(255) - up_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			case (sext_s5)
				SextRy: begin
					red_s6   <= ChanW'(255);
					green_s6 <= up_s5;
					blue_s6  <= '0;
				end
				SextYg: begin
					red_s6   <= down_s5;
					green_s6 <= ChanW'(255);
					blue_s6  <= '0;
				end
				SextGc: begin
					red_s6   <= '0;
					green_s6 <= ChanW'(255);
					blue_s6  <= up_s5;
				end
				SextCb: begin
					red_s6   <= '0;
					green_s6 <= down_s5;
					blue_s6  <= ChanW'(255);
				end
				SextBm: begin
					red_s6   <= up_s5;
					green_s6 <= '0;
					blue_s6  <= ChanW'(255);
				end
				SextMr: begin
					red_s6   <= ChanW'(255);
					green_s6 <= '0;
					blue_s6  <= down_s5;
				end
				default: begin
					red_s6   <= '0;
					green_s6 <= '0;
					blue_s6  <= '0;
				end
			endcase
			x_s6 <= x_s5;
			y_s6 <= y_s5;
		end
	end

	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;
	assign sq_x  = x_s6;
	assign sq_y  = y_s6;

endmodule

// ===== rtl/hsvpg_shade.sv =====
module hsvpg_shade (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hsvpg_pkg::ChanW-1:0]   c,
	input  logic [hsvpg_pkg::DimW-1:0]    x,
	input  logic [hsvpg_pkg::DimW-1:0]    y,
	input  logic [hsvpg_pkg::DimW-1:0]    width,
	input  logic [hsvpg_pkg::DimW-1:0]    height,
	input  logic [hsvpg_pkg::RecW-1:0]    rw,
	input  logic [hsvpg_pkg::RecW-1:0]    rh,
	output logic [hsvpg_pkg::ChanW-1:0]   c_out,
	output logic [hsvpg_pkg::ChanW-1:0]   pix
);
	import hsvpg_pkg::*;

	localparam int EstPW = ChanW + RecW;
	localparam int QwPW  = RecW + DimW;

	logic [ChanW-1:0] d;
	logic [EstPW-1:0] qa_prod;
	logic [RecW-1:0]  d1000;
	logic [QwPW-1:0]  qw_prod;
	logic [RecW-1:0]  ra_full;
	logic             ra_ge;
	logic [QwPW-1:0]  wx_prod;
	logic [Div1000OutW-1:0] wq;
	logic [EstPW-1:0] qb_prod;
	logic [RecW-1:0]  a1000;
	logic [QwPW-1:0]  qh_prod;
	logic [RecW-1:0]  rb_full;
	logic             rb_ge;
	logic [QwPW-1:0]  hy_prod;
	logic [Div1000OutW-1:0] hq;

	logic [ChanW-1:0] d_s1;
	logic [RecW-1:0]  qa_s1, qa_s2;
	logic [DimW:0]    ra_s2;
	logic [RecW-1:0]  wc_s3;
	logic [QwPW-1:0]  wx_s4;
	logic [ChanW-1:0] a_s5, a_s6, a_s7, a_s8, a_s9;
	logic [RecW-1:0]  qb_s6, qb_s7;
	logic [DimW:0]    rb_s7;
	logic [RecW-1:0]  hc_s8;
	logic [QwPW-1:0]  hy_s9;
	logic [ChanW-1:0] pix_s10;
	logic [ChanW-1:0] c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;
	logic [DimW-1:0]  x_s1, x_s2, x_s3;
	logic [DimW-1:0]  y_s1, y_s2, y_s3, y_s4, y_s5, y_s6, y_s7, y_s8;

	// Whitening step: floor((255-c)*1000/w) from the held floor(256000/w),
	// then one correction, then the column product scaled down by 1000.
	assign d       = ChanW'(255) - c;
	assign qa_prod = EstPW'(d) * EstPW'(rw);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= d;
			qa_s1 <= qa_prod[EstPW-1:ChanW];
			c_s1  <= c;
			x_s1  <= x;
			y_s1  <= y;
		end
	end

	assign d1000   = RecW'(d_s1) * RecW'(Thousand);
	assign qw_prod = QwPW'(qa_s1) * QwPW'(width);
	assign ra_full = d1000 - qw_prod[RecW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s2 <= qa_s1;
			ra_s2 <= ra_full[DimW:0];
			c_s2  <= c_s1;
			x_s2  <= x_s1;
			y_s2  <= y_s1;
		end
	end

	assign ra_ge = ra_s2 >= {1'b0, width};

	always_ff @(posedge clk) begin
		if (en) begin
			wc_s3 <= qa_s2 + RecW'(ra_ge);
			c_s3  <= c_s2;
			x_s3  <= x_s2;
			y_s3  <= y_s2;
		end
	end

	assign wx_prod = QwPW'(wc_s3) * QwPW'(x_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s4 <= wx_prod;
			c_s4  <= c_s3;
			y_s4  <= y_s3;
		end
	end

	assign wq = div1000(Div1000InW'(wx_s4));

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5 <= c_s4 + wq[ChanW-1:0];
			c_s5 <= c_s4;
			y_s5 <= y_s4;
		end
	end

	// Darkening step, same shape with the height and the row.
	assign qb_prod = EstPW'(a_s5) * EstPW'(rh);

	always_ff @(posedge clk) begin
		if (en) begin
			qb_s6 <= qb_prod[EstPW-1:ChanW];
			a_s6  <= a_s5;
			c_s6  <= c_s5;
			y_s6  <= y_s5;
		end
	end

	assign a1000   = RecW'(a_s6) * RecW'(Thousand);
	assign qh_prod = QwPW'(qb_s6) * QwPW'(height);
	assign rb_full = a1000 - qh_prod[RecW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			qb_s7 <= qb_s6;
			rb_s7 <= rb_full[DimW:0];
			a_s7  <= a_s6;
			c_s7  <= c_s6;
			y_s7  <= y_s6;
		end
	end

	assign rb_ge = rb_s7 >= {1'b0, height};

	always_ff @(posedge clk) begin
		if (en) begin
			hc_s8 <= qb_s7 + RecW'(rb_ge);
			a_s8  <= a_s7;
			c_s8  <= c_s7;
			y_s8  <= y_s7;
		end
	end

	assign hy_prod = QwPW'(hc_s8) * QwPW'(y_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			hy_s9 <= hy_prod;
			a_s9  <= a_s8;
			c_s9  <= c_s8;
		end
	end

	assign hq = div1000(Div1000InW'(hy_s9));

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s10 <= a_s9 - hq[ChanW-1:0];
			c_s10   <= c_s9;
		end
	end

	assign pix   = pix_s10;
	assign c_out = c_s10;

endmodule

// ===== rtl/hue_sat_value_pixel_generator.sv =====
// Hue bar and picker square pixel generator.
//
// Input words arrive on the s_ stream: a hue position and a square
// coordinate. Each accepted word yields one output word on the m_ stream
// with the hue bar color and the shaded square pixel color.
// Throughput is one word per clock while m_tready is high and no recompute
// runs. A word accepted at one rising edge passes through sixteen register
// stages from input to output before it shows on m_tdata with m_tvalid high.
// The sixteen stages all advance together; when the receiver holds m_tready
// low with a word waiting, the whole pipeline holds and s_tready drops, so
// nothing is lost or repeated.
// Configuration must be written through cfg_wen/cfg_index/cfg_wdata while the
// stream is idle; the block does not enforce this. Every write recomputes four
// reciprocals in a shared bit-serial divider, which holds s_tready low. Reset
// empties the pipeline and loads segment 66 and square 400 by 400, with their
// reciprocals preset, so words are taken right after reset.
module hue_sat_value_pixel_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// hue_position [12:0], square_x [23:13], square_y [34:24], zero [39:35]
	input  logic [hsvpg_pkg::InDataW-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// hue_red [7:0], hue_green [15:8], hue_blue [23:16],
	// pixel_red [31:24], pixel_green [39:32], pixel_blue [47:40]
	output logic [hsvpg_pkg::OutDataW-1:0] m_tdata,
	input  logic                           cfg_wen,
	input  logic [hsvpg_pkg::IdxW-1:0]     cfg_index,
	input  logic [hsvpg_pkg::DimW-1:0]     cfg_wdata
);
	import hsvpg_pkg::*;

	hsvpg_cfg_t       cfg;
	logic             busy;
	logic             adv;
	logic [Latency-1:0] vld_q;
	logic [ChanW-1:0] hue_r, hue_g, hue_b;
	logic [DimW-1:0]  sq_x, sq_y;
	logic [ChanW-1:0] out_hr, out_hg, out_hb;
	logic [ChanW-1:0] pix_r, pix_g, pix_b;

	assign adv      = m_tready || !vld_q[Latency-1];
	assign s_tready = adv && !busy;
	assign m_tvalid = vld_q[Latency-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Latency-2:0], s_tvalid && s_tready};
		end
	end

	hsvpg_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.busy      (busy)
	);

	hsvpg_hue u_hue (
		.clk   (clk),
		.en    (adv),
		.pos   (s_tdata[PosW-1:0]),
		.x     (s_tdata[PosW+DimW-1:PosW]),
		.y     (s_tdata[PosW+2*DimW-1:PosW+DimW]),
		.cfg   (cfg),
		.red   (hue_r),
		.green (hue_g),
		.blue  (hue_b),
		.sq_x  (sq_x),
		.sq_y  (sq_y)
	);

	hsvpg_shade u_shade_r (
		.clk    (clk),
		.en     (adv),
		.c      (hue_r),
		.x      (sq_x),
		.y      (sq_y),
		.width  (cfg.width),
		.height (cfg.height),
		.rw     (cfg.rw),
		.rh     (cfg.rh),
		.c_out  (out_hr),
		.pix    (pix_r)
	);

	hsvpg_shade u_shade_g (
		.clk    (clk),
		.en     (adv),
		.c      (hue_g),
		.x      (sq_x),
		.y      (sq_y),
		.width  (cfg.width),
		.height (cfg.height),
		.rw     (cfg.rw),
		.rh     (cfg.rh),
		.c_out  (out_hg),
		.pix    (pix_g)
	);

	hsvpg_shade u_shade_b (
		.clk    (clk),
		.en     (adv),
		.c      (hue_b),
		.x      (sq_x),
		.y      (sq_y),
		.width  (cfg.width),
		.height (cfg.height),
		.rw     (cfg.rw),
		.rh     (cfg.rh),
		.c_out  (out_hb),
		.pix    (pix_b)
	);

	assign m_tdata = {pix_b, pix_g, pix_r, out_hb, out_hg, out_hr};

endmodule

// ===== sim/tb_hue_sat_value_pixel_generator.sv =====
`timescale 1ns / 100ps

module tb_hue_sat_value_pixel_generator;
	import hsvpg_pkg::*;

	localparam int CycleLimit = 400000;

	// Index that maps to no register.
	localparam logic [IdxW-1:0] RegUnused = 2'd3;

	// Expected output word, hue_red in the lowest byte up to pixel_blue.
	typedef logic [5:0][ChanW-1:0] color_word_t;

	class pixel_scoreboard;
		logic [SegW-1:0] seg;
		logic [DimW-1:0] width;
		logic [DimW-1:0] height;
		color_word_t pending_colors[$];
		int unsigned errors;

		function new();
			seg = SegReset;
			width = DimReset;
			height = DimReset;
			errors = 0;
		endfunction

		function void set_register(logic [IdxW-1:0] idx, logic [DimW-1:0] val);
			case (idx)
				RegSeg: begin
					seg = val[SegW-1:0];
				end
				RegWidth: begin
					width = val;
				end
				RegHeight: begin
					height = val;
				end
				default: begin
				end
			endcase
		endfunction

		function int unsigned eff_seg();
			return (seg == 0) ? 1 : seg;
		endfunction

		function int unsigned eff_width();
			return (width == 0) ? 1 : width;
		endfunction

		function int unsigned eff_height();
			return (height == 0) ? 1 : height;
		endfunction

		// Whitens across the square, then darkens down it.
		function logic [ChanW-1:0] shade_channel(int unsigned c, int unsigned x,
				int unsigned y, int unsigned w, int unsigned h);
			int unsigned a;
			int unsigned o;
			a = c + ((255 - c) * 1000 / w) * x / 1000;
			o = a - (a * 1000 / h) * y / 1000;
			return o[ChanW-1:0];
		endfunction

		function color_word_t predict_colors(logic [PosW-1:0] pos, logic [DimW-1:0] x_in,
				logic [DimW-1:0] y_in);
			int unsigned sl;
			int unsigned w;
			int unsigned h;
			int unsigned p;
			int unsigned sext;
			int unsigned m;
			int unsigned up;
			int unsigned down;
			int unsigned r;
			int unsigned g;
			int unsigned b;
			int unsigned x;
			int unsigned y;
			color_word_t c;
			sl = eff_seg();
			w = eff_width();
			h = eff_height();
			p = pos % (6 * sl);
			sext = p / sl;
			m = p % sl;
			up = (255000 / sl) * m / 1000;
			down = 255 - up;
			case (3'(sext))
				SextRy: begin
					r = 255; g = up; b = 0;
				end
				SextYg: begin
					r = down; g = 255; b = 0;
				end
				SextGc: begin
					r = 0; g = 255; b = up;
				end
				SextCb: begin
					r = 0; g = down; b = 255;
				end
				SextBm: begin
					r = up; g = 0; b = 255;
				end
				default: begin
					r = 255; g = 0; b = down;
				end
			endcase
			x = (x_in > w - 1) ? w - 1 : x_in;
			y = (y_in > h - 1) ? h - 1 : y_in;
			c[0] = r[ChanW-1:0];
			c[1] = g[ChanW-1:0];
			c[2] = b[ChanW-1:0];
			c[3] = shade_channel(r, x, y, w, h);
			c[4] = shade_channel(g, x, y, w, h);
			c[5] = shade_channel(b, x, y, w, h);
			return c;
		endfunction

		function void note_word(logic [PosW-1:0] pos, logic [DimW-1:0] x,
				logic [DimW-1:0] y);
			pending_colors.push_back(predict_colors(pos, x, y));
		endfunction

		function string chan_name(int i);
			case (i)
				0: return "hue_red";
				1: return "hue_green";
				2: return "hue_blue";
				3: return "pixel_red";
				4: return "pixel_green";
				default: return "pixel_blue";
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(logic [OutDataW-1:0] data);
			color_word_t got;
			color_word_t want;
			got = data;
			if (pending_colors.size() == 0) begin
				report($sformatf("unexpected word %h", data));
			end else begin
				want = pending_colors.pop_front();
				for (int i = 0; i < 6; i++) begin
					if (got[i] !== want[i])
						report($sformatf("%s got %0d expected %0d", chan_name(i),
							got[i], want[i]));
				end
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_wen = 1'b0;
	logic [IdxW-1:0]     cfg_index = '0;
	logic [DimW-1:0]     cfg_wdata = '0;

	bit calm = 1'b0;
	int unsigned cycle_count = 0;
	pixel_scoreboard sb = new();

	hue_sat_value_pixel_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		forever begin
			@(negedge clk);
			m_tready <= calm || ($urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("hue_sat_value_pixel_generator test failed");
		$finish;
	end

	task send_word(logic [PosW-1:0] pos, logic [DimW-1:0] x, logic [DimW-1:0] y);
		if (!calm && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 31);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, y, x, pos};
		do @(posedge clk); while (!s_tready);
		sb.note_word(pos, x, y);
		@(negedge clk);
	endtask

	// Always waits on a falling clock edge before it returns, so valid is never
	// dropped and raised again in the same step.
	task wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending_colors.size() != 0);
	endtask

	task write_reg(logic [IdxW-1:0] idx, logic [DimW-1:0] val);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		sb.set_register(idx, val);
		// The reciprocal recompute holds s_tready low.
		while (!s_tready) @(negedge clk);
	endtask

	task set_config(logic [DimW-1:0] seg, logic [DimW-1:0] w, logic [DimW-1:0] h);
		write_reg(RegSeg, seg);
		write_reg(RegWidth, w);
		write_reg(RegHeight, h);
	endtask

	task send_random_word();
		int unsigned span;
		logic [PosW-1:0] pos;
		logic [DimW-1:0] x;
		logic [DimW-1:0] y;
		span = 6 * sb.eff_seg();
		pos = ($urandom_range(99) < 50) ? PosW'($urandom_range(span - 1, 0))
			: PosW'($urandom_range(8191, 0));
		x = ($urandom_range(99) < 70) ? DimW'($urandom_range(sb.eff_width() - 1, 0))
			: DimW'($urandom_range(2047, 0));
		y = ($urandom_range(99) < 70) ? DimW'($urandom_range(sb.eff_height() - 1, 0))
			: DimW'($urandom_range(2047, 0));
		send_word(pos, x, y);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: segment edges, wrap and coordinate clamping.
		send_word(0, 0, 0);
		send_word(33, 200, 200);
		send_word(65, 399, 0);
		send_word(66, 0, 399);
		send_word(99, 100, 300);
		send_word(165, 250, 50);
		send_word(231, 10, 390);
		send_word(297, 398, 398);
		send_word(363, 1, 1);
		send_word(395, 200, 0);
		send_word(396, 0, 200);
		send_word(8191, 2047, 2047);
		send_word(1000, 400, 400);

		// Zero registers act as one; bit 10 of a segment write is dropped.
		set_config(11'h400, 0, 0);
		send_word(0, 0, 0);
		send_word(5, 2047, 2047);
		send_word(8191, 1, 1);

		// Unknown index leaves the settings alone.
		write_reg(RegUnused, 11'h7FF);
		send_word(7, 0, 0);

		set_config(11'h7FF, 11'h7FF, 11'h7FF);
		send_word(8191, 2047, 2047);
		send_word(6137, 2046, 2046);
		send_word(6138, 1023, 0);
		send_word(5626, 0, 2047);
		send_word(2046, 2047, 0);

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_config(1, 1, 1);
				2: set_config(1023, 2047, 2047);
				3: set_config(DimW'($urandom_range(12, 1)), DimW'($urandom_range(20, 1)),
					DimW'($urandom_range(20, 1)));
				5: set_config(DimW'(SegResetVal), DimReset, DimReset);
				default: set_config(DimW'($urandom_range(2047, 0)),
					DimW'($urandom_range(2047, 0)), DimW'($urandom_range(2047, 0)));
			endcase
			calm = (phase == 2);
			for (int i = 0; i < 100; i++)
				send_random_word();
			calm = 1'b0;
		end

		wait_drained();
		repeat (Latency + 4) @(negedge clk);
		if (sb.errors == 0 && sb.pending_colors.size() == 0)
			$display("hue_sat_value_pixel_generator test passed");
		else
			$display("hue_sat_value_pixel_generator test failed");
		$finish;
	end

endmodule
